>>> sv/wbps_pkg.sv
`default_nettype none
package wbps_pkg;

  localparam int MAX_PATTERN = 64;
  localparam int OFFSET_BITS = 32;

  localparam int LEN_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam int POS_W = OFFSET_BITS + 1;

  localparam logic [1:0] REQ_CLEAR  = 2'd0;
  localparam logic [1:0] REQ_APPEND = 2'd1;
  localparam logic [1:0] REQ_BYTE   = 2'd2;

  typedef struct packed {
    logic       wild;
    logic [7:0] value;
  } elem_t;

  typedef struct packed {
    logic clear;
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage
`default_nettype wire

>>> sv/wildcard_byte_pattern_scan.sv
`default_nettype none
// Wildcard byte pattern scan. A clear item (tuser 0) empties the pattern and
// restarts the scan, append items (tuser 1) add one pattern element each, up
// to 64, and module byte items (tuser 2, tlast on the final byte) are
// compared against the pattern by a row of cells, one per element, that pass
// partial-match flags along every byte. The block takes one item per cycle;
// each item is done in that cycle, and a result appears in the output
// register on the next cycle. The only stall is a result that has not been
// taken: input waits until the output register is free or drained that
// cycle. One result per scan: found with offset and base plus offset at the
// first full match, or not found after the last byte. module_base is written
// on the cfg channel only while idle, a user's duty the block does not enforce.
module wildcard_byte_pattern_scan
  import wbps_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [63:0]  cfg_data,     // module_base
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [23:0]  in_tdata,     // pattern_byte[7:0], pattern_wild[8], data_byte[16:9]
  input  wire logic [1:0]   in_tuser,     // req_type[1:0]
  input  wire logic         in_tlast,     // data_last
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [95:0]       out_tdata,    // match_offset[31:0], match_address[95:32]
  output logic              out_tuser     // found
);

  logic [63:0]            base_r;
  logic [LEN_W-1:0]       len_r, len_nxt;
  logic [POS_W-1:0]       pos_r, pos_nxt;
  logic                   done_r, done_nxt;
  logic                   out_valid_r, out_valid_nxt;
  logic                   out_found_r, out_found_nxt;
  logic [OFFSET_BITS-1:0] out_off_r, out_off_nxt;

  logic        in_acc;
  logic [7:0]  pat_byte;
  logic        pat_wild;
  logic [7:0]  dat_byte;
  logic        is_byte;
  logic        in_range;
  logic        len_zero;
  logic        full_hit;
  logic        res_fire;
  logic        shift;
  logic [IDX_W-1:0] last_idx;
  logic [OFFSET_BITS-1:0] hit_off;
  logic [63:0] addr;

  logic [MAX_PATTERN-1:0] flags;
  logic [MAX_PATTERN-1:0] flags_nxt;
  cell_ctl_t              ctl [MAX_PATTERN];
  elem_t                  wr_elem;

  assign cfg_ready = 1'b1;
  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;

  assign pat_byte = in_tdata[7:0];
  assign pat_wild = in_tdata[8];
  assign dat_byte = in_tdata[16:9];
  assign wr_elem  = '{wild: pat_wild, value: pat_byte};

  assign is_byte  = in_acc && (in_tuser == REQ_BYTE) && !done_r;
  assign in_range = !pos_r[OFFSET_BITS];
  assign len_zero = (len_r == '0);
  assign shift    = is_byte && in_range && !len_zero;
  assign last_idx = IDX_W'(len_r - LEN_W'(1));
  assign full_hit = flags_nxt[last_idx];
  assign hit_off  = OFFSET_BITS'(pos_r - POS_W'(len_r - LEN_W'(1)));

  // Row of cells; cell k matches pattern element k.
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic active;
    logic prev;
    assign active = (LEN_W'(k) < len_r);
    assign ctl[k].clear = in_acc && (in_tuser == REQ_CLEAR);
    assign ctl[k].shift = shift;
    assign ctl[k].write = in_acc && (in_tuser == REQ_APPEND) && (len_r == LEN_W'(k));
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = flags[k-1];
    end
    wbps_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl[k]),
      .wr_elem   (wr_elem),
      .active    (active),
      .data_byte (dat_byte),
      .prev_flag (prev),
      .flag      (flags[k]),
      .flag_nxt  (flags_nxt[k])
    );
  end

  always_comb begin
    len_nxt       = len_r;
    pos_nxt       = pos_r;
    done_nxt      = done_r;
    out_valid_nxt = out_valid_r && !out_tready;
    out_found_nxt = out_found_r;
    out_off_nxt   = out_off_r;
    res_fire      = 1'b0;
    if (in_acc) begin
      unique case (in_tuser)
        REQ_CLEAR: begin
          len_nxt  = '0;
          pos_nxt  = '0;
          done_nxt = 1'b0;
        end
        REQ_APPEND: begin
          if (len_r < LEN_W'(MAX_PATTERN)) begin
            len_nxt = len_r + LEN_W'(1);
          end
        end
        REQ_BYTE: begin
          if (!done_r) begin
            if (in_range && len_zero) begin
              res_fire      = 1'b1;
              out_found_nxt = 1'b1;
              out_off_nxt   = '0;
            end else if (in_range && full_hit) begin
              res_fire      = 1'b1;
              out_found_nxt = 1'b1;
              out_off_nxt   = hit_off;
            end else begin
              if (in_range) begin
                pos_nxt = pos_r + POS_W'(1);
              end
              if (in_tlast) begin
                res_fire      = 1'b1;
                out_found_nxt = 1'b0;
                out_off_nxt   = '0;
              end
            end
            if (res_fire) begin
              done_nxt      = 1'b1;
              out_valid_nxt = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r      <= '0;
      len_r       <= '0;
      pos_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        base_r <= cfg_data;
      end
      len_r       <= len_nxt;
      pos_r       <= pos_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_found_r <= out_found_nxt;
    out_off_r   <= out_off_nxt;
  end

  // The base is to change only while idle (the block does not enforce it), so
  // the address add sits after the output register.
  assign addr       = out_found_r ? (base_r + 64'(out_off_r)) : 64'd0;
  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_found_r;
  assign out_tdata  = {addr, 32'(out_off_r)};

  a_result_from_item : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(in_acc))
    else $error("result appeared without an accepted item");

  a_done_after_result : assert property (@(posedge clk) disable iff (!rst_n)
    res_fire |=> done_r)
    else $error("scan not closed after a result");

  a_len_bound : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(MAX_PATTERN))
    else $error("pattern length past capacity");

  a_not_found_zero : assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_off_r == '0))
    else $error("not-found result carries an offset");

endmodule
`default_nettype wire

>>> sv/wbps_cell.sv
`default_nettype none
module wbps_cell
  import wbps_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  var  cell_ctl_t  ctl,
  input  var  elem_t      wr_elem,
  input  wire logic       active,
  input  wire logic [7:0] data_byte,
  input  wire logic       prev_flag,
  output logic            flag,
  output logic            flag_nxt
);

  elem_t elem_r;
  logic  flag_r;

  // The flag says that this element and all before it matched up to the
  // previous byte; the left neighbor hands in its old flag.
  assign flag_nxt = active && prev_flag && (elem_r.wild || (elem_r.value == data_byte));
  assign flag     = flag_r;

  always_ff @(posedge clk) begin
    if (ctl.write) begin
      elem_r <= wr_elem;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || ctl.clear) begin
      flag_r <= 1'b0;
    end else if (ctl.shift) begin
      flag_r <= flag_nxt;
    end
  end

endmodule
`default_nettype wire
